>>> design/gbn_pkg.sv
// Shared types and constants for the go-back-N sender window block.
package gbn_pkg;

    localparam int WINDOW = 10;
    localparam int SEQ_W = 16;
    localparam int SEQ_X_W = SEQ_W + 1;
    localparam logic [SEQ_W-1:0] SEQ_LIMIT = '1;

    typedef enum logic [1:0] {
        OP_APPEND  = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_NONE    = 2'd3
    } op_t;

    localparam logic [1:0] TMR_LEAVE   = 2'd0;
    localparam logic [1:0] TMR_RESTART = 2'd1;
    localparam logic [1:0] TMR_STOP    = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECODE,
        ST_PLAN,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MODE_EMPTY,
        MODE_MOVE,
        MODE_RETX
    } mode_t;

    typedef struct packed {
        logic [1:0]       operation;
        logic [SEQ_W-1:0] ack_number;
        logic             ack_intact;
    } in_word_t;

    typedef struct packed {
        logic             send_valid;
        logic [SEQ_W-1:0] send_number;
        logic [1:0]       timer_action;
        logic             refused;
        logic             last;
    } out_word_t;

    typedef struct packed {
        logic capture;
        logic decode;
        logic plan;
        logic emit;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic word_last;
    } status_t;

endpackage

>>> design/go_back_n_sender_window.sv
// Top level of the go-back-N sender window controller.
// Each input word is one event (append, cumulative ack, timer expiry or no-op) and yields 1 to WINDOW
// output words, the final one flagged last and carrying the timer command and refusal flag.
// After it is accepted an event passes through the decode and window planning states, then
// emits one output word per cycle while the output side does not stall, set by the single send
// cursor that steps through the window; input ready returns the cycle after the last word is
// loaded into the output register.
module go_back_n_sender_window (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  gbn_pkg::in_word_t   in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output gbn_pkg::out_word_t  out_data
);

    gbn_pkg::cmd_t    cmd;
    gbn_pkg::status_t status;

    gbn_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    gbn_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (in_data),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

endmodule

>>> design/gbn_datapath.sv
// Datapath: window counters, send cursor and the output word register.
module gbn_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  gbn_pkg::cmd_t       cmd,
    output gbn_pkg::status_t    status,
    input  gbn_pkg::in_word_t   in_data,
    output gbn_pkg::out_word_t  out_data,
    output logic                out_valid,
    input  logic                out_ready
);

    gbn_pkg::in_word_t  item_reg;
    gbn_pkg::out_word_t out_reg, out_next;
    logic               out_valid_reg, out_valid_next;

    logic [gbn_pkg::SEQ_X_W-1:0] base_reg, base_next;
    logic [gbn_pkg::SEQ_X_W-1:0] nxt_reg, nxt_next;
    logic [gbn_pkg::SEQ_W-1:0]   queued_reg, queued_next;
    logic [gbn_pkg::SEQ_X_W-1:0] cursor_reg, cursor_next;
    logic [gbn_pkg::SEQ_X_W-1:0] limit_reg, limit_next;
    gbn_pkg::mode_t              mode_reg, mode_next;
    logic [1:0]                  timer_reg, timer_next;
    logic                        refused_reg, refused_next;
    logic                        is_ack_reg, is_ack_next;

    logic [gbn_pkg::SEQ_X_W-1:0] ack_next_seq;
    logic [gbn_pkg::SEQ_X_W-1:0] win_end;
    logic [gbn_pkg::SEQ_X_W-1:0] queue_end;
    logic [gbn_pkg::SEQ_X_W-1:0] move_limit;
    logic [gbn_pkg::SEQ_X_W-1:0] final_nxt;
    logic [gbn_pkg::SEQ_X_W-1:0] cursor_inc;
    logic                        has_send;
    logic                        ack_ok;

    always_comb
    begin
        ack_next_seq = {1'b0, item_reg.ack_number} + gbn_pkg::SEQ_X_W'(1);
        ack_ok = item_reg.ack_intact && (ack_next_seq >= base_reg)
                 && (ack_next_seq <= nxt_reg);
        win_end = base_reg + gbn_pkg::SEQ_X_W'(gbn_pkg::WINDOW);
        queue_end = {1'b0, queued_reg} + gbn_pkg::SEQ_X_W'(1);
        move_limit = (win_end < queue_end) ? win_end : queue_end;
        final_nxt = (nxt_reg < move_limit) ? move_limit : nxt_reg;
        cursor_inc = cursor_reg + gbn_pkg::SEQ_X_W'(1);
        has_send = cursor_reg < limit_reg;
    end

    always_comb
    begin
        base_next = base_reg;
        nxt_next = nxt_reg;
        queued_next = queued_reg;
        cursor_next = cursor_reg;
        limit_next = limit_reg;
        mode_next = mode_reg;
        timer_next = timer_reg;
        refused_next = refused_reg;
        is_ack_next = is_ack_reg;
        out_next = out_reg;
        out_valid_next = out_valid_reg;

        if (cmd.decode)
        begin
            refused_next = 1'b0;
            is_ack_next = 1'b0;
            mode_next = gbn_pkg::MODE_EMPTY;
            timer_next = gbn_pkg::TMR_LEAVE;
            unique case (gbn_pkg::op_t'(item_reg.operation))
                gbn_pkg::OP_APPEND:
                begin
                    if (queued_reg == gbn_pkg::SEQ_LIMIT)
                    begin
                        refused_next = 1'b1;
                    end
                    else
                    begin
                        queued_next = queued_reg + gbn_pkg::SEQ_W'(1);
                        mode_next = gbn_pkg::MODE_MOVE;
                        timer_next = gbn_pkg::TMR_RESTART;
                    end
                end
                gbn_pkg::OP_ACK:
                begin
                    if (ack_ok)
                    begin
                        base_next = ack_next_seq;
                        mode_next = gbn_pkg::MODE_MOVE;
                        is_ack_next = 1'b1;
                    end
                end
                gbn_pkg::OP_TIMEOUT:
                begin
                    mode_next = gbn_pkg::MODE_RETX;
                    timer_next = gbn_pkg::TMR_RESTART;
                end
                gbn_pkg::OP_NONE:
                begin
                    mode_next = gbn_pkg::MODE_EMPTY;
                end
                default:
                begin
                    mode_next = gbn_pkg::MODE_EMPTY;
                end
            endcase
        end

        if (cmd.plan)
        begin
            unique case (mode_reg)
                gbn_pkg::MODE_MOVE:
                begin
                    cursor_next = nxt_reg;
                    limit_next = move_limit;
                    if (is_ack_reg)
                    begin
                        timer_next = (base_reg == final_nxt) ? gbn_pkg::TMR_STOP
                                                             : gbn_pkg::TMR_RESTART;
                    end
                end
                gbn_pkg::MODE_RETX:
                begin
                    cursor_next = base_reg;
                    limit_next = nxt_reg;
                end
                default:
                begin
                    cursor_next = '0;
                    limit_next = '0;
                end
            endcase
        end

        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
            out_next.send_valid = has_send;
            out_next.send_number = has_send ? cursor_reg[gbn_pkg::SEQ_W-1:0] : '0;
            out_next.last = status.word_last;
            out_next.timer_action = status.word_last ? timer_reg : gbn_pkg::TMR_LEAVE;
            out_next.refused = status.word_last ? refused_reg : 1'b0;
            if (has_send)
            begin
                cursor_next = cursor_inc;
                if (mode_reg == gbn_pkg::MODE_MOVE)
                begin
                    nxt_next = cursor_inc;
                end
            end
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign status.word_last = !has_send || (cursor_inc == limit_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= gbn_pkg::SEQ_X_W'(1);
            nxt_reg <= gbn_pkg::SEQ_X_W'(1);
            queued_reg <= '0;
            mode_reg <= gbn_pkg::MODE_EMPTY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            base_reg <= base_next;
            nxt_reg <= nxt_next;
            queued_reg <= queued_next;
            mode_reg <= mode_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_reg <= in_data;
        end
        cursor_reg <= cursor_next;
        limit_reg <= limit_next;
        timer_reg <= timer_next;
        refused_reg <= refused_next;
        is_ack_reg <= is_ack_next;
        out_reg <= out_next;
    end

    assign out_data = out_reg;
    assign out_valid = out_valid_reg;

endmodule

>>> design/gbn_ctrl.sv
// Controller: sequences decode, planning and word emission for one event.
module gbn_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  gbn_pkg::status_t  status,
    output gbn_pkg::cmd_t     cmd
);

    gbn_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gbn_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            gbn_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next = gbn_pkg::ST_DECODE;
                end
            end
            gbn_pkg::ST_DECODE:
            begin
                cmd.decode = 1'b1;
                state_next = gbn_pkg::ST_PLAN;
            end
            gbn_pkg::ST_PLAN:
            begin
                cmd.plan = 1'b1;
                state_next = gbn_pkg::ST_EMIT;
            end
            gbn_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (status.word_last)
                    begin
                        state_next = gbn_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = gbn_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

>>> design/gbn_checker.sv
// Port checker for the go-back-N sender window, bound to the top level.
module gbn_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input gbn_pkg::out_word_t  out_data
);

    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data);
    endproperty

    property p_busy_after_accept;
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready;
    endproperty

    property p_inner_word_sends;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.last |->
            out_data.send_valid && out_data.timer_action == gbn_pkg::TMR_LEAVE
            && !out_data.refused;
    endproperty

    property p_refused_alone;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_data.refused |->
            out_data.last && !out_data.send_valid
            && out_data.timer_action == gbn_pkg::TMR_LEAVE;
    endproperty

    a_out_hold: assert property (p_out_hold)
        else $error("output word changed while stalled");
    a_busy_after_accept: assert property (p_busy_after_accept)
        else $error("input ready right after accepting an event");
    a_inner_word_sends: assert property (p_inner_word_sends)
        else $error("non-final word without a send or with a final-only field");
    a_refused_alone: assert property (p_refused_alone)
        else $error("refused append carried a send or a timer command");

endmodule

bind go_back_n_sender_window gbn_checker u_gbn_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
